// ===== design/rdc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types, constants and the digit alphabet for the radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 7;
    localparam int UPC_W   = 3;

    localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [DIGIT_W-1:0] RADIX_MAX   = 6'd62;
    localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd10;

    typedef logic [UPC_W-1:0] upc_t;

    // microprogram addresses
    localparam upc_t UPC_IDLE     = 3'd0;
    localparam upc_t UPC_CHECK    = 3'd1;
    localparam upc_t UPC_DIV_INIT = 3'd2;
    localparam upc_t UPC_DIV_STEP = 3'd3;
    localparam upc_t UPC_WAIT_OUT = 3'd4;
    localparam upc_t UPC_BRANCH   = 3'd5;
    localparam upc_t UPC_ERR      = 3'd6;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_EMIT_DIGIT,
        OP_EMIT_ERR
    } op_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_IN_VALID,
        COND_CNT_ZERO,
        COND_OUT_FREE,
        COND_Q_ZERO,
        COND_RADIX_BAD
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  gated;      // op takes effect only when cond holds
        upc_t  tgt_true;
        upc_t  tgt_false;
    } ucode_word_t;

    typedef struct packed {
        op_t  op;
        logic fire;
    } rdc_ctl_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic cnt_zero;
        logic q_zero;
        logic radix_bad;
    } rdc_status_t;

    // alphabet 0-9, a-z, A-Z
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        c = '0;
        if (d < 6'd10)
            c = 7'd48 + {1'b0, d};
        else if (d < 6'd36)
            c = 7'd87 + {1'b0, d};
        else if (d < 6'd62)
            c = 7'd29 + {1'b0, d};
        return c;
    endfunction

endpackage

// ===== design/rdc_sequencer.sv =====
// ----------------------------------------------------------------------------
// rdc_sequencer
// Microprogram counter, control store and branch logic.
// ----------------------------------------------------------------------------
module rdc_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  rdc_pkg::rdc_status_t status,
    output rdc_pkg::rdc_ctl_t    ctl
);
    import rdc_pkg::*;

    upc_t        upc_reg;
    upc_t        upc_next;
    ucode_word_t word;
    logic        cond_ok;

    // control store
    always_comb
    begin
        case (upc_reg)
            UPC_IDLE:     word = '{OP_LOAD,       COND_IN_VALID,  1'b1, UPC_CHECK,    UPC_IDLE};
            UPC_CHECK:    word = '{OP_NONE,       COND_RADIX_BAD, 1'b0, UPC_ERR,      UPC_DIV_INIT};
            UPC_DIV_INIT: word = '{OP_DIV_INIT,   COND_ALWAYS,    1'b0, UPC_DIV_STEP, UPC_DIV_STEP};
            UPC_DIV_STEP: word = '{OP_DIV_STEP,   COND_CNT_ZERO,  1'b0, UPC_WAIT_OUT, UPC_DIV_STEP};
            UPC_WAIT_OUT: word = '{OP_EMIT_DIGIT, COND_OUT_FREE,  1'b1, UPC_BRANCH,   UPC_WAIT_OUT};
            UPC_BRANCH:   word = '{OP_NONE,       COND_Q_ZERO,    1'b0, UPC_IDLE,     UPC_DIV_INIT};
            UPC_ERR:      word = '{OP_EMIT_ERR,   COND_OUT_FREE,  1'b1, UPC_IDLE,     UPC_ERR};
            default:      word = '{OP_NONE,       COND_ALWAYS,    1'b0, UPC_IDLE,     UPC_IDLE};
        endcase
    end

    always_comb
    begin
        case (word.cond)
            COND_ALWAYS:    cond_ok = 1'b1;
            COND_IN_VALID:  cond_ok = status.in_valid;
            COND_CNT_ZERO:  cond_ok = status.cnt_zero;
            COND_OUT_FREE:  cond_ok = status.out_free;
            COND_Q_ZERO:    cond_ok = status.q_zero;
            COND_RADIX_BAD: cond_ok = status.radix_bad;
            default:        cond_ok = 1'b0;
        endcase
        upc_next = cond_ok ? word.tgt_true : word.tgt_false;
        ctl.op   = word.op;
        ctl.fire = !word.gated || cond_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= UPC_IDLE;
        else
            upc_reg <= upc_next;
    end

endmodule

// ===== design/rdc_datapath.sv =====
// ----------------------------------------------------------------------------
// rdc_datapath
// Radix register, bit-serial restoring divider and output register.
// ----------------------------------------------------------------------------
module rdc_datapath #(
    parameter int VALUE_BITS = 31
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rdc_pkg::rdc_ctl_t           ctl,
    output rdc_pkg::rdc_status_t        status,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rdc_pkg::DIGIT_W-1:0] radix,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [VALUE_BITS-1:0]       value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [rdc_pkg::DIGIT_W-1:0] digit_value,
    output logic [rdc_pkg::CHAR_W-1:0]  digit_char,
    output logic                        last,
    output logic                        error
);
    import rdc_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS);

    logic [DIGIT_W-1:0]    radix_reg;
    logic [VALUE_BITS-1:0] q_reg;
    logic [DIGIT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  out_valid_reg;
    logic [DIGIT_W-1:0]    digit_value_reg;
    logic [CHAR_W-1:0]     digit_char_reg;
    logic                  last_reg;
    logic                  error_reg;

    logic [DIGIT_W:0]      trial;
    logic [DIGIT_W:0]      diff;
    logic                  q_bit;
    logic                  out_free;

    assign cfg_ready = 1'b1;
    assign in_stall  = (ctl.op != OP_LOAD);
    assign out_free  = !out_valid_reg || !out_stall;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, q_reg[VALUE_BITS-1]};
    assign diff  = trial - {1'b0, radix_reg};
    assign q_bit = (trial >= {1'b0, radix_reg});

    assign status.in_valid  = in_valid;
    assign status.out_free  = out_free;
    assign status.cnt_zero  = (cnt_reg == '0);
    assign status.q_zero    = (q_reg == '0);
    assign status.radix_bad = (radix_reg < RADIX_MIN) || (radix_reg > RADIX_MAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= RADIX_RESET;
        else if (cfg_valid && cfg_ready)
            radix_reg <= radix;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.fire)
        begin
            case (ctl.op)
                OP_LOAD:
                begin
                    q_reg <= value;
                end
                OP_DIV_INIT:
                begin
                    rem_reg <= '0;
                    cnt_reg <= CNT_W'(VALUE_BITS - 1);
                end
                OP_DIV_STEP:
                begin
                    rem_reg <= q_bit ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
                    q_reg   <= {q_reg[VALUE_BITS-2:0], q_bit};
                    cnt_reg <= cnt_reg - 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.fire && (ctl.op == OP_EMIT_DIGIT || ctl.op == OP_EMIT_ERR))
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.fire && ctl.op == OP_EMIT_DIGIT)
        begin
            digit_value_reg <= rem_reg;
            digit_char_reg  <= digit_to_char(rem_reg);
            last_reg        <= (q_reg == '0);
            error_reg       <= 1'b0;
        end
        else if (ctl.fire && ctl.op == OP_EMIT_ERR)
        begin
            digit_value_reg <= '0;
            digit_char_reg  <= '0;
            last_reg        <= 1'b1;
            error_reg       <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign digit_value = digit_value_reg;
    assign digit_char  = digit_char_reg;
    assign last        = last_reg;
    assign error       = error_reg;

endmodule

// ===== design/radix_digit_converter_top.sv =====
// ----------------------------------------------------------------------------
// radix_digit_converter_top
// Converts a non-negative integer to base 2..62 digits, least significant first.
// ----------------------------------------------------------------------------
// A value beat is taken only when the sequencer sits at its idle step, and the
// block then emits one result beat per digit, least significant digit first,
// with last set on the most significant digit. A radix outside 2..62 gives one
// error beat. Each digit comes from a bit-serial restoring divider that retires
// one dividend bit per cycle; a digit takes one init step, VALUE_BITS divide
// steps, an output write that waits while the output is stalled, and one branch.
// The radix register resets to 10 and is written through its own valid/ready
// channel; the user must write it only while no item is in flight, as the block
// itself does not enforce this (cfg_ready is always high).
module radix_digit_converter_top #(
    parameter int VALUE_BITS = 31
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rdc_pkg::DIGIT_W-1:0] radix,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [VALUE_BITS-1:0]       value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [rdc_pkg::DIGIT_W-1:0] digit_value,
    output logic [rdc_pkg::CHAR_W-1:0]  digit_char,
    output logic                        last,
    output logic                        error
);
    import rdc_pkg::*;

    rdc_ctl_t    ctl;
    rdc_status_t status;

    rdc_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctl    (ctl)
    );

    rdc_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .radix       (radix),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digit_value (digit_value),
        .digit_char  (digit_char),
        .last        (last),
        .error       (error)
    );

    // in the cycle after a value beat is accepted, the input is stalled
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted on consecutive cycles");

    // an error beat carries no digit and closes the item
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> last && digit_value == '0 && digit_char == '0)
        else $error("malformed error beat");

    // a digit beat always has a legal digit and a printable symbol
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !error |-> digit_value <= 6'd61 && digit_char != '0)
        else $error("digit beat out of range");

endmodule
